FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, held off while rst_ni is low.
`define MFQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Concurrent assertion on clk_i that also runs during reset.
`define MFQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");

`endif

FILE: hw/rtl/mfq_pkg.sv
// Shared constants, types and codes of the feedback queue scheduler.
package mfq_pkg;

  localparam int MAX_TASKS  = 32;
  localparam int NUM_LEVELS = 4;
  localparam int TASK_W     = 5;
  localparam int LVL_W      = 2;
  localparam int PTR_W      = TASK_W + 1;
  localparam int CNT_W      = 6;
  localparam int TIME_W     = 16;
  localparam int WORK_W     = 10;
  localparam int QUANT_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int FIFO_DEPTH = NUM_LEVELS * MAX_TASKS;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOT0   = 3'd4;

  localparam logic [QUANT_W-1:0] QUANT_RESET [NUM_LEVELS] = '{8'd1, 8'd2, 8'd4, 8'd8};
  localparam logic [WORK_W-1:0]  ALLOT_RESET [NUM_LEVELS] = '{10'd4, 10'd8, 10'd16, 10'd0};

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_SWEEP_RD,
    CMD_SWEEP_WR,
    CMD_SCAN_RD,
    CMD_SCAN_WR,
    CMD_FIFO_RD,
    CMD_POP,
    CMD_LOAD,
    CMD_RUN,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TIME_W-1:0] arrival;
    logic [WORK_W-1:0] burst;
  } in_item_t;

  typedef struct packed {
    logic              idle;
    logic [TASK_W-1:0] ran_task;
    logic [LVL_W-1:0]  ran_level;
    logic [TIME_W-1:0] time_after;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] response;
    logic              all_done;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [WORK_W-1:0] burst;
    logic [WORK_W-1:0] remaining;
    logic [WORK_W-1:0] used;
    logic              started;
    logic              queued;
    logic [TIME_W-1:0] response;
  } task_rec_t;

  typedef struct packed {
    logic idx_end;
    logic active;
    logic any_queue;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/multilevel_feedback_queue_scheduler.sv
// Top level of the four-level feedback queue scheduler.
//
// Usage: drive one beat per command on the input channel (in_valid_i /
// in_ready_o). kind selects append task, advance one time unit, restart
// schedule or clear tasks; only an advance beat yields one result beat on
// the output channel (out_valid_o / out_ready_i). Registers are written on
// the configuration channel, which is always ready; write them only while
// the block is idle.
// Work per beat, with L loaded tasks: append writes one task slot; restart
// does one read and one write per task slot in the table RAM. An advance
// runs an arrival scan over the task table (a read and a write per slot);
// if a task is active or queued, queue pop and record load follow, after a
// queue read when none is active; then come run, a second arrival scan and
// finish. in_ready_o is high only between commands. The result sits in an
// output register; if the receiver stalls with a result still held, the
// next advance waits in its finish step until that beat is taken.
// Reset: asynchronous, active low; clears queues, time and counts and
// restores default quanta and allotments. The task table needs no clear.
module multilevel_feedback_queue_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mfq_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mfq_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mfq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mfq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mfq_pkg::*;

  cmd_e       cmd;
  dp_status_t status;

  // Sequence each command beat through the datapath.
  mfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_kind_i  (in_data_i.kind),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold task table, queues, slice state and the output register.
  mfq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

endmodule

FILE: hw/rtl/mfq_ram.sv
// Generic simple dual-port RAM with registered read.
module mfq_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mfq_ctrl.sv
// Sequencer of the scheduler: steps the datapath through each beat.
module mfq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_kind_i,
  input  mfq_pkg::dp_status_t status_i,
  output mfq_pkg::cmd_e       cmd_o
);
  import mfq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_SCAN_A_RD,
    ST_SCAN_A_WR,
    ST_FIFO_RD,
    ST_POP,
    ST_LOAD,
    ST_RUN,
    ST_SCAN_B_RD,
    ST_SCAN_B_WR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o = CMD_ACCEPT;
          unique case (kind_e'(in_kind_i))
            KIND_APPEND:                state_d = ST_IDLE;
            KIND_TICK:                  state_d = ST_SCAN_A_RD;
            KIND_RESTART, KIND_CLEAR:   state_d = ST_SWEEP_RD;
            default:                    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP_RD: begin
        if (status_i.idx_end) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o   = CMD_SWEEP_RD;
          state_d = ST_SWEEP_WR;
        end
      end
      ST_SWEEP_WR: begin
        cmd_o   = CMD_SWEEP_WR;
        state_d = ST_SWEEP_RD;
      end
      ST_SCAN_A_RD: begin
        if (status_i.idx_end) begin
          if (status_i.active) state_d = ST_POP;
          else if (status_i.any_queue) state_d = ST_FIFO_RD;
          else state_d = ST_RUN;
        end else begin
          cmd_o   = CMD_SCAN_RD;
          state_d = ST_SCAN_A_WR;
        end
      end
      ST_SCAN_A_WR: begin
        cmd_o   = CMD_SCAN_WR;
        state_d = ST_SCAN_A_RD;
      end
      ST_FIFO_RD: begin
        cmd_o   = CMD_FIFO_RD;
        state_d = ST_POP;
      end
      ST_POP: begin
        cmd_o   = CMD_POP;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o   = CMD_LOAD;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o   = CMD_RUN;
        state_d = ST_SCAN_B_RD;
      end
      ST_SCAN_B_RD: begin
        if (status_i.idx_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o   = CMD_SCAN_RD;
          state_d = ST_SCAN_B_WR;
        end
      end
      ST_SCAN_B_WR: begin
        cmd_o   = CMD_SCAN_WR;
        state_d = ST_SCAN_B_RD;
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o   = CMD_FINISH;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: hw/rtl/mfq_dp.sv
// Datapath of the scheduler: task table, level queues, slice and time state.
module mfq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfq_pkg::cmd_e                 cmd_i,
  output mfq_pkg::dp_status_t           status_o,
  input  mfq_pkg::in_item_t             in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [mfq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mfq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output mfq_pkg::out_item_t            out_data_o
);
  import mfq_pkg::*;

  localparam int FAW = $clog2(FIFO_DEPTH);
  localparam int RECW = $bits(task_rec_t);

  logic [QUANT_W-1:0] quantum_q [NUM_LEVELS];
  logic [WORK_W-1:0]  allot_q   [NUM_LEVELS];

  logic [CNT_W-1:0]  loaded_q, loaded_d, done_q, done_d, idx_q, idx_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [PTR_W-1:0]  head_q [NUM_LEVELS];
  logic [PTR_W-1:0]  head_d [NUM_LEVELS];
  logic [PTR_W-1:0]  tail_q [NUM_LEVELS];
  logic [PTR_W-1:0]  tail_d [NUM_LEVELS];
  logic [TASK_W-1:0] act_task_q, act_task_d;
  logic [LVL_W-1:0]  act_level_q, act_level_d;
  logic              active_q, active_d, slice_new_q, slice_new_d;
  logic [WORK_W-1:0] slice_q, slice_d;
  task_rec_t         rec_q, rec_d;
  logic              ran_idle_q, ran_idle_d;
  logic [TASK_W-1:0] ran_task_q, ran_task_d;
  logic [LVL_W-1:0]  ran_level_q, ran_level_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              t_we;
  logic [TASK_W-1:0] t_waddr, t_raddr;
  task_rec_t         t_wdata, t_rdata;
  logic [RECW-1:0]   t_rdata_raw;
  logic              f_we;
  logic [FAW-1:0]    f_waddr, f_raddr;
  logic [TASK_W-1:0] f_wdata, f_rdata;

  logic [LVL_W-1:0]  sel_lvl;
  logic              any_queue, out_busy;

  mfq_ram #(.Width(RECW), .Depth(MAX_TASKS)) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata_raw)
  );
  assign t_rdata = task_rec_t'(t_rdata_raw);

  mfq_ram #(.Width(TASK_W), .Depth(FIFO_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // Highest non-empty level.
  always_comb begin
    any_queue = 1'b0;
    sel_lvl   = '0;
    for (int q = NUM_LEVELS - 1; q >= 0; q--) begin
      if (head_q[q] != tail_q[q]) begin
        any_queue = 1'b1;
        sel_lvl   = LVL_W'(q);
      end
    end
  end

  assign out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    logic [WORK_W-1:0] qt, len, left, allot_v;
    logic              fin, seg_end, demote;
    logic [TASK_W-1:0] tsel;
    logic [LVL_W-1:0]  plvl;
    qt      = '0;
    len     = '0;
    left    = '0;
    allot_v = allot_q[act_level_q];
    fin     = 1'b0;
    seg_end = 1'b0;
    demote  = 1'b0;
    tsel    = '0;
    plvl    = act_level_q;

    loaded_d    = loaded_q;
    done_d      = done_q;
    idx_d       = idx_q;
    time_d      = time_q;
    head_d      = head_q;
    tail_d      = tail_q;
    act_task_d  = act_task_q;
    act_level_d = act_level_q;
    active_d    = active_q;
    slice_new_d = slice_new_q;
    slice_d     = slice_q;
    rec_d       = rec_q;
    ran_idle_d  = ran_idle_q;
    ran_task_d  = ran_task_q;
    ran_level_d = ran_level_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    t_we    = 1'b0;
    t_waddr = idx_q[TASK_W-1:0];
    t_wdata = rec_q;
    t_raddr = idx_q[TASK_W-1:0];
    f_we    = 1'b0;
    f_waddr = {{LVL_W{1'b0}}, tail_q[0][TASK_W-1:0]};
    f_wdata = idx_q[TASK_W-1:0];
    f_raddr = {sel_lvl, head_q[sel_lvl][TASK_W-1:0]};

    unique case (cmd_i)
      CMD_NONE: ;
      CMD_ACCEPT: begin
        unique case (kind_e'(in_data_i.kind))
          KIND_APPEND: begin
            if (loaded_q != CNT_W'(MAX_TASKS)) begin
              t_we              = 1'b1;
              t_waddr           = loaded_q[TASK_W-1:0];
              t_wdata           = '0;
              t_wdata.arrival   = in_data_i.arrival;
              t_wdata.burst     = in_data_i.burst;
              t_wdata.remaining = in_data_i.burst;
              loaded_d = loaded_q + CNT_W'(1);
              done_d   = done_q + CNT_W'(in_data_i.burst == '0);
            end
          end
          KIND_TICK: idx_d = '0;
          KIND_RESTART, KIND_CLEAR: begin
            done_d      = '0;
            idx_d       = '0;
            time_d      = '0;
            active_d    = 1'b0;
            act_task_d  = '0;
            act_level_d = '0;
            slice_d     = '0;
            slice_new_d = 1'b0;
            for (int q = 0; q < NUM_LEVELS; q++) begin
              head_d[q] = '0;
              tail_d[q] = '0;
            end
            if (kind_e'(in_data_i.kind) == KIND_CLEAR) loaded_d = '0;
          end
          default: ;
        endcase
      end
      CMD_SWEEP_RD, CMD_SCAN_RD: ;
      CMD_SWEEP_WR: begin
        t_we              = 1'b1;
        t_wdata           = t_rdata;
        t_wdata.remaining = t_rdata.burst;
        t_wdata.used      = '0;
        t_wdata.started   = 1'b0;
        t_wdata.queued    = 1'b0;
        t_wdata.response  = '0;
        done_d = done_q + CNT_W'(t_rdata.burst == '0);
        idx_d  = idx_q + CNT_W'(1);
      end
      CMD_SCAN_WR: begin
        if (t_rdata.arrival == time_q && t_rdata.remaining != '0 && !t_rdata.queued) begin
          t_we           = 1'b1;
          t_wdata        = t_rdata;
          t_wdata.queued = 1'b1;
          f_we           = 1'b1;
          tail_d[0]      = tail_q[0] + PTR_W'(1);
        end
        idx_d = idx_q + CNT_W'(1);
      end
      CMD_FIFO_RD: begin
        head_d[sel_lvl] = head_q[sel_lvl] + PTR_W'(1);
        act_level_d     = sel_lvl;
        slice_new_d     = 1'b1;
      end
      CMD_POP: begin
        tsel       = slice_new_q ? f_rdata : act_task_q;
        act_task_d = tsel;
        t_raddr    = tsel;
      end
      CMD_LOAD: begin
        rec_d = t_rdata;
        if (slice_new_q) begin
          if (!t_rdata.started) begin
            rec_d.started  = 1'b1;
            rec_d.response = time_q - t_rdata.arrival;
          end
          qt  = (quantum_q[act_level_q] == '0) ? WORK_W'(1)
                                               : WORK_W'(quantum_q[act_level_q]);
          len = (t_rdata.remaining < qt) ? t_rdata.remaining : qt;
          if (allot_v != '0) begin
            left = (t_rdata.used >= allot_v) ? '0 : allot_v - t_rdata.used;
            if (len > left) len = left;
          end
          if (len == '0) len = WORK_W'(1);
          slice_d     = len;
          active_d    = 1'b1;
          slice_new_d = 1'b0;
        end
      end
      CMD_RUN: begin
        ran_idle_d  = !active_q;
        ran_task_d  = active_q ? act_task_q : '0;
        ran_level_d = active_q ? act_level_q : '0;
        if (active_q) begin
          if (rec_q.remaining != '0) rec_d.remaining = rec_q.remaining - WORK_W'(1);
          if (rec_q.used != '1) rec_d.used = rec_q.used + WORK_W'(1);
          if (slice_q != '0) slice_d = slice_q - WORK_W'(1);
          t_we    = 1'b1;
          t_waddr = act_task_q;
          t_wdata = rec_d;
        end
        if (time_q != '1) time_d = time_q + TIME_W'(1);
        idx_d = '0;
      end
      CMD_FINISH: begin
        seg_end = active_q && (slice_q == '0 || rec_q.remaining == '0);
        fin     = seg_end && (rec_q.remaining == '0);
        demote  = seg_end && !fin && (allot_v != '0) && (rec_q.used >= allot_v);
        if (fin) done_d = done_q + CNT_W'(1);
        if (seg_end) begin
          active_d = 1'b0;
          slice_d  = '0;
        end
        if (demote) begin
          rec_d.used = '0;
          t_we       = 1'b1;
          t_waddr    = act_task_q;
          t_wdata    = rec_d;
          plvl       = act_level_q + LVL_W'(1);
        end
        if (seg_end && !fin) begin
          f_we          = 1'b1;
          f_waddr       = {plvl, tail_q[plvl][TASK_W-1:0]};
          f_wdata       = act_task_q;
          tail_d[plvl]  = tail_q[plvl] + PTR_W'(1);
        end
        out_valid_d      = 1'b1;
        out_d.idle       = ran_idle_q;
        out_d.ran_task   = ran_task_q;
        out_d.ran_level  = ran_level_q;
        out_d.time_after = time_q;
        out_d.finished   = fin;
        out_d.turnaround = fin ? time_q - rec_q.arrival : '0;
        out_d.response   = fin ? rec_q.response : '0;
        out_d.all_done   = (done_d == loaded_d);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      done_q      <= '0;
      idx_q       <= '0;
      time_q      <= '0;
      act_task_q  <= '0;
      act_level_q <= '0;
      active_q    <= 1'b0;
      slice_new_q <= 1'b0;
      slice_q     <= '0;
      out_valid_q <= 1'b0;
      for (int q = 0; q < NUM_LEVELS; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
      end
    end else begin
      loaded_q    <= loaded_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      time_q      <= time_d;
      act_task_q  <= act_task_d;
      act_level_q <= act_level_d;
      active_q    <= active_d;
      slice_new_q <= slice_new_d;
      slice_q     <= slice_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q       <= rec_d;
    ran_idle_q  <= ran_idle_d;
    ran_task_q  <= ran_task_d;
    ran_level_q <= ran_level_d;
    out_q       <= out_d;
  end

  // Configuration registers; the lowest level keeps an unlimited allotment.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_LEVELS; q++) begin
        quantum_q[q] <= QUANT_RESET[q];
        allot_q[q]   <= ALLOT_RESET[q];
      end
    end else if (cfg_valid_i) begin
      for (int q = 0; q < NUM_LEVELS; q++) begin
        if (cfg_index_i == CFG_QUANTUM0 + CFG_IDX_W'(q)) begin
          quantum_q[q] <= cfg_data_i[QUANT_W-1:0];
        end
        if (q < NUM_LEVELS - 1 && cfg_index_i == CFG_ALLOT0 + CFG_IDX_W'(q)) begin
          allot_q[q] <= cfg_data_i[WORK_W-1:0];
        end
      end
    end
  end

  assign status_o.idx_end   = (idx_q == loaded_q);
  assign status_o.active    = active_q;
  assign status_o.any_queue = any_queue;
  assign status_o.out_busy  = out_busy;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

FILE: hw/rtl/mfq_checker.sv
// Port-level checker of the scheduler and its bind.
`include "assert_macros.svh"

module mfq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input mfq_pkg::in_item_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input mfq_pkg::out_item_t            out_data_o
);
  import mfq_pkg::*;

  `MFQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `MFQ_ASSERT(a_idle_clean, out_valid_o && out_data_o.idle |-> !out_data_o.finished && out_data_o.ran_task == '0 && out_data_o.ran_level == '0)
  `MFQ_ASSERT(a_unfinished_zero, out_valid_o && !out_data_o.finished |-> out_data_o.turnaround == '0 && out_data_o.response == '0)
  `MFQ_ASSERT(a_tick_busy, in_valid_i && in_ready_o && in_data_i.kind == KIND_TICK |=> !in_ready_o)
  `MFQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o || $past(rst_ni))

endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (.*);
